[rtl/quaternion_to_euler_angles_macros.svh]
// Assertion helpers for the RTL (used by qte_queue).
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

`ifndef ASSERT_OFF
`define QTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QTE_ASSERT(lbl, prop, msg)
`define QTE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/qte_pkg.sv]
package qte_pkg;

  localparam int NW = 35;           // products and sums, units of 2^-28
  localparam int SW = 30;           // clamped asin argument
  localparam int VW = 57;           // isqrt radicand
  localparam int CWID = 29;         // isqrt root
  localparam int CW = 46;           // CORDIC vector
  localparam int AW = 34;           // angle, units of 2^-30 rad
  localparam int ISQ_STAGES = 29;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [22:0] DEG_PER_RAD = 23'sd3754936;
  localparam logic signed [NW-1:0] ONE_S = 35'sd268435456;

  typedef struct packed {
    logic signed [NW-1:0] roll_n;
    logic signed [NW-1:0] roll_d;
    logic signed [NW-1:0] yaw_n;
    logic signed [NW-1:0] yaw_d;
    logic signed [SW-1:0] s;
    logic                 clamped;
  } qte_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qte_qstat_t;

  function automatic logic signed [AW-1:0] atan_step(input int i);
    logic signed [AW-1:0] t;
    unique case (i)
      0:  t = 34'h3243F6A8;
      1:  t = 34'h1DAC6705;
      2:  t = 34'h0FADBAFC;
      3:  t = 34'h07F56EA6;
      4:  t = 34'h03FEAB76;
      5:  t = 34'h01FFD55B;
      6:  t = 34'h00FFFAAA;
      7:  t = 34'h007FFF55;
      8:  t = 34'h003FFFEA;
      9:  t = 34'h001FFFFD;
      10: t = 34'h000FFFFF;
      11: t = 34'h0007FFFF;
      12: t = 34'h0003FFFF;
      13: t = 34'h0001FFFF;
      14: t = 34'h0000FFFF;
      15: t = 34'h00007FFF;
      16: t = 34'h00003FFF;
      17: t = 34'h00001FFF;
      18: t = 34'h00000FFF;
      19: t = 34'h000007FF;
      20: t = 34'h000003FF;
      21: t = 34'h000001FF;
      22: t = 34'h000000FF;
      23: t = 34'h0000007F;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [57:0] v);
    logic signed [15:0] r;
    priority if (v > 58'sd32767) r = 16'sh7FFF;
    else if (v < -58'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

[rtl/qte_if.sv]
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] q_w;
  logic signed [15:0] q_x;
  logic signed [15:0] q_y;
  logic signed [15:0] q_z;
  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic signed [15:0] yaw;
  logic               clamped;
  modport source (output valid, roll, pitch, yaw, clamped, input ready);
  modport sink (input valid, roll, pitch, yaw, clamped, output ready);
endinterface

interface qte_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/qte_front.sv]
module qte_front (
  input  logic                  clk,
  input  logic                  rst_n,
  qte_in_if.sink                in_ch,
  input  qte_pkg::qte_qstat_t   qstat,
  output logic                  push,
  output qte_pkg::qte_item_t    item
);

  logic va_r, vb_r, en;
  logic signed [31:0] pww_r, pxx_r, pyy_r, pzz_r, pyz_r, pwx_r, pxy_r, pwz_r, pxz_r, pwy_r;
  logic signed [qte_pkg::NW-1:0] s0;
  qte_pkg::qte_item_t item_r, item_nxt;

  // whole front stalls only when a finished item cannot enter the queue
  assign en = !(vb_r && qstat.full);
  assign in_ch.ready = en;
  assign push = vb_r && !qstat.full;
  assign item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_ch.valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pww_r <= in_ch.q_w * in_ch.q_w;
      pxx_r <= in_ch.q_x * in_ch.q_x;
      pyy_r <= in_ch.q_y * in_ch.q_y;
      pzz_r <= in_ch.q_z * in_ch.q_z;
      pyz_r <= in_ch.q_y * in_ch.q_z;
      pwx_r <= in_ch.q_w * in_ch.q_x;
      pxy_r <= in_ch.q_x * in_ch.q_y;
      pwz_r <= in_ch.q_w * in_ch.q_z;
      pxz_r <= in_ch.q_x * in_ch.q_z;
      pwy_r <= in_ch.q_w * in_ch.q_y;
    end
  end

  always_comb begin
    item_nxt.roll_n = (35'(pyz_r) + 35'(pwx_r)) <<< 1;
    item_nxt.roll_d = 35'(pww_r) - 35'(pxx_r) - 35'(pyy_r) + 35'(pzz_r);
    item_nxt.yaw_n  = (35'(pxy_r) + 35'(pwz_r)) <<< 1;
    item_nxt.yaw_d  = 35'(pww_r) + 35'(pxx_r) - 35'(pyy_r) - 35'(pzz_r);
    s0 = (35'(pwy_r) - 35'(pxz_r)) <<< 1;
    priority if (s0 > qte_pkg::ONE_S) begin
      item_nxt.s = 30'(qte_pkg::ONE_S);
      item_nxt.clamped = 1'b1;
    end else if (s0 < -qte_pkg::ONE_S) begin
      item_nxt.s = 30'(-qte_pkg::ONE_S);
      item_nxt.clamped = 1'b1;
    end else begin
      item_nxt.s = s0[qte_pkg::SW-1:0];
      item_nxt.clamped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) item_r <= item_nxt;
  end

endmodule

[rtl/qte_queue.sv]
`include "quaternion_to_euler_angles_macros.svh"

module qte_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qte_pkg::qte_item_t  item_in,
  input  logic                pop,
  output qte_pkg::qte_item_t  item_out,
  output qte_pkg::qte_qstat_t qstat
);

  localparam int PW = $clog2(qte_pkg::QUEUE_DEPTH);

  qte_pkg::qte_item_t slot_r [qte_pkg::QUEUE_DEPTH];
  logic [PW-1:0] head_r, tail_r;
  logic [PW:0]   cnt_r;

  assign qstat.full  = cnt_r == (PW+1)'(qte_pkg::QUEUE_DEPTH);
  assign qstat.empty = cnt_r == '0;
  assign item_out = slot_r[head_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[tail_r] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) tail_r <= tail_r + 1'b1;
      if (pop) head_r <= head_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `QTE_ASSERT(a_no_overflow, !(push && qstat.full && !pop), "push into full queue")
  `QTE_ASSERT(a_no_underflow, !(pop && qstat.empty), "pop from empty queue")
  `QTE_ASSERT(a_drain, (pop && !push && cnt_r == 1) |=> qstat.empty, "queue not empty after last pop")

endmodule

[rtl/qte_cordic.sv]
module qte_cordic #(
  parameter int STEPS = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [qte_pkg::NW-1:0]  x_i,
  input  logic signed [qte_pkg::NW-1:0]  y_i,
  output logic signed [qte_pkg::AW-1:0]  a_o
);

  localparam int CW = qte_pkg::CW;
  localparam int AW = qte_pkg::AW;
  localparam logic signed [AW-1:0] HALF_PI = qte_pkg::atan_step(0) <<< 1;

  logic signed [CW-1:0] xs, ys;
  logic signed [CW-1:0] x_r [STEPS+1];
  logic signed [CW-1:0] y_r [STEPS+1];
  logic signed [AW-1:0] a_r [STEPS+1];

  assign xs = {{(CW-qte_pkg::NW-8){x_i[qte_pkg::NW-1]}}, x_i, 8'b0};
  assign ys = {{(CW-qte_pkg::NW-8){y_i[qte_pkg::NW-1]}}, y_i, 8'b0};

  // left half plane: turn by a quarter first
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (xs < 0 && ys >= 0) begin
        x_r[0] <= ys;
        y_r[0] <= -xs;
        a_r[0] <= HALF_PI;
      end else if (xs < 0) begin
        x_r[0] <= -ys;
        y_r[0] <= xs;
        a_r[0] <= -HALF_PI;
      end else begin
        x_r[0] <= xs;
        y_r[0] <= ys;
        a_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [AW-1:0] TI = qte_pkg::atan_step(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          a_r[i+1] <= a_r[i] + TI;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          a_r[i+1] <= a_r[i] - TI;
        end
      end
    end
  end

  assign a_o = a_r[STEPS];

endmodule

[rtl/qte_back.sv]
module qte_back #(
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                unit,
  input  qte_pkg::qte_qstat_t qstat,
  input  qte_pkg::qte_item_t  item,
  output logic                pop,
  qte_out_if.source           out_ch
);

  localparam int NW = qte_pkg::NW;
  localparam int AW = qte_pkg::AW;
  localparam int VW = qte_pkg::VW;
  localparam int ISQ = qte_pkg::ISQ_STAGES;
  localparam int NV = ISQ + STEPS + 3;
  localparam logic [VW-1:0] ONE56 = VW'(1) << 56;

  logic en;
  logic [NV-1:0] vld_r;
  logic signed [2*qte_pkg::SW-1:0] sq;
  logic [VW-1:0] v_r [ISQ+1];
  logic [VW-1:0] r_r [ISQ+1];
  qte_pkg::qte_item_t it_r [ISQ+1];
  logic clp_r [STEPS+2];
  logic signed [AW-1:0] ang [3];
  logic signed [AW-1:0] pa_r [3];
  logic signed [56:0]   pd_r [3];
  logic signed [NW-1:0] cx [3];
  logic signed [NW-1:0] cy [3];
  logic signed [15:0]   res [3];

  logic               out_valid_r;
  logic signed [15:0] roll_r, pitch_r, yaw_r;
  logic               clamped_r;

  // single stall for the whole back pipeline: output register full and held
  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NV-2:0], pop};
  end

  assign sq = item.s * item.s;

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= item;
      v_r[0]  <= ONE56 - VW'(sq);
      r_r[0]  <= '0;
    end
  end

  // restoring square root, one root bit per stage
  for (genvar k = 0; k < ISQ; k++) begin : g_isq
    localparam logic [VW-1:0] BITV = VW'(1) << (56 - 2*k);
    logic [VW-1:0] trial;
    assign trial = r_r[k] + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        it_r[k+1] <= it_r[k];
        if (v_r[k] >= trial) begin
          v_r[k+1] <= v_r[k] - trial;
          r_r[k+1] <= (r_r[k] >> 1) + BITV;
        end else begin
          v_r[k+1] <= v_r[k];
          r_r[k+1] <= r_r[k] >> 1;
        end
      end
    end
  end

  assign cy[0] = it_r[ISQ].roll_n;
  assign cx[0] = it_r[ISQ].roll_d;
  assign cy[1] = NW'(it_r[ISQ].s);
  assign cx[1] = {{(NW-qte_pkg::CWID){1'b0}}, r_r[ISQ][qte_pkg::CWID-1:0]};
  assign cy[2] = it_r[ISQ].yaw_n;
  assign cx[2] = it_r[ISQ].yaw_d;

  for (genvar c = 0; c < 3; c++) begin : g_ang
    qte_cordic #(.STEPS(STEPS)) u_cordic (
      .clk (clk),
      .en  (en),
      .x_i (cx[c]),
      .y_i (cy[c]),
      .a_o (ang[c])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        pa_r[c] <= ang[c];
        pd_r[c] <= ang[c] * qte_pkg::DEG_PER_RAD;
      end
    end

    always_comb begin
      logic signed [NW-1:0] rad;
      logic signed [57:0]   deg;
      rad = (NW'(pa_r[c]) + 35'sd65536) >>> 17;
      deg = (58'(pd_r[c]) + (58'sd1 <<< 38)) >>> 39;
      res[c] = unit ? qte_pkg::sat16(deg) : qte_pkg::sat16(58'(rad));
    end
  end

  // clamp flag rides alongside the CORDIC and product stages
  always_ff @(posedge clk) begin
    if (en) begin
      clp_r[0] <= it_r[ISQ].clamped;
      for (int j = 0; j < STEPS + 1; j++) clp_r[j+1] <= clp_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vld_r[NV-1];
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[NV-1]) begin
      roll_r    <= res[0];
      pitch_r   <= res[1];
      yaw_r     <= res[2];
      clamped_r <= clp_r[STEPS+1];
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.roll    = roll_r;
  assign out_ch.pitch   = pitch_r;
  assign out_ch.yaw     = yaw_r;
  assign out_ch.clamped = clamped_r;

endmodule

[rtl/quaternion_to_euler_angles.sv]
// channel   dir  payload                         handshake
// in_ch     in   q_w q_x q_y q_z (Q1.14)         valid/ready
// out_ch    out  roll pitch yaw (16b), clamped   valid/ready
// cfg_ch    in   data = angle_unit               valid/ready, always ready
//
// One item per cycle sustained while out_ch accepts results; every stage is pipelined
// (products, 29-stage square root, CORDIC_STEPS-stage CORDIC per angle, unit scaling).
// A held result stalls only the back pipeline; the front keeps accepting
// until the 4-entry queue fills. Synchronous active-low reset clears
// valids, queue pointers and angle_unit (radians).
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  qte_in_if.sink     in_ch,
  qte_out_if.source  out_ch,
  qte_cfg_if.sink    cfg_ch
);

  logic angle_unit_r;
  logic push, pop;
  qte_pkg::qte_item_t  f_item, q_item;
  qte_pkg::qte_qstat_t qstat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) angle_unit_r <= 1'b0;
    else if (cfg_ch.valid) angle_unit_r <= cfg_ch.data;
  end

  qte_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push),
    .item  (f_item)
  );

  qte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item_in  (f_item),
    .pop      (pop),
    .item_out (q_item),
    .qstat    (qstat)
  );

  qte_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .unit   (angle_unit_r),
    .qstat  (qstat),
    .item   (q_item),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

[verif/qte_scoreboard.sv]
module qte_scoreboard #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  qte_in_if    in_mon,
  qte_out_if   out_mon,
  qte_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  localparam longint ONE_Q28 = 64'sd1 << 28;
  localparam longint DEG_PER_RAD_Q16 = 64'sd3754936;

  longint atan_lut [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  logic   unit_deg;
  euler_t angles_due [$];

  assign pending = angles_due.size();

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(input longint yv, input longint xv);
    longint a, t, dx, dy;
    a = 0;
    xv = xv * 256;
    yv = yv * 256;
    // pre-rotate left half-plane by a quarter turn
    if (xv < 0) begin
      if (yv >= 0) begin
        t = xv; xv = yv; yv = -t; a = 2 * atan_lut[0];
      end else begin
        t = xv; xv = -yv; yv = t; a = -2 * atan_lut[0];
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv = xv + dx; yv = yv - dy; a = a + atan_lut[i];
      end else begin
        xv = xv - dx; yv = yv + dy; a = a - atan_lut[i];
      end
    end
    return a;
  endfunction

  function automatic logic signed [15:0] scale_angle(input longint a, input logic deg);
    longint r;
    if (deg) r = (a * DEG_PER_RAD_Q16 + (64'sd1 <<< 38)) >>> 39;
    else r = (a + (64'sd1 <<< 16)) >>> 17;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic euler_t predict_euler(input logic signed [15:0] qw, input logic signed [15:0] qx,
                                           input logic signed [15:0] qy, input logic signed [15:0] qz,
                                           input logic deg);
    longint w, x, y, z, rn, rd, yn, yd, s, c;
    euler_t e;
    w = qw; x = qx; y = qy; z = qz;
    rn = 2 * (y * z + w * x);
    rd = w * w - x * x - y * y + z * z;
    yn = 2 * (x * y + w * z);
    yd = w * w + x * x - y * y - z * z;
    s = -2 * (x * z - w * y);
    e.clamped = 1'b0;
    if (s > ONE_Q28) begin s = ONE_Q28; e.clamped = 1'b1; end
    if (s < -ONE_Q28) begin s = -ONE_Q28; e.clamped = 1'b1; end
    c = int_sqrt((64'd1 << 56) - longint'(s * s));
    e.roll = scale_angle(vector_angle(rn, rd), deg);
    e.pitch = scale_angle(vector_angle(s, c), deg);
    e.yaw = scale_angle(vector_angle(yn, yd), deg);
    return e;
  endfunction

  always @(posedge clk) begin
    euler_t e;
    if (!rst_n) begin
      unit_deg <= 1'b0;
      angles_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) unit_deg <= cfg_mon.data;
      if (in_mon.valid && in_mon.ready)
        angles_due.push_back(predict_euler(in_mon.q_w, in_mon.q_x, in_mon.q_y, in_mon.q_z,
                                           unit_deg));
      if (out_mon.valid && out_mon.ready) begin
        if (angles_due.size() == 0) begin
          $error("unexpected item: roll %0d pitch %0d yaw %0d", out_mon.roll, out_mon.pitch,
                 out_mon.yaw);
          fail_count++;
        end else begin
          e = angles_due.pop_front();
          if (out_mon.roll !== e.roll) begin
            $error("roll: expected %0d, got %0d", e.roll, out_mon.roll);
            fail_count++;
          end
          if (out_mon.pitch !== e.pitch) begin
            $error("pitch: expected %0d, got %0d", e.pitch, out_mon.pitch);
            fail_count++;
          end
          if (out_mon.yaw !== e.yaw) begin
            $error("yaw: expected %0d, got %0d", e.yaw, out_mon.yaw);
            fail_count++;
          end
          if (out_mon.clamped !== e.clamped) begin
            $error("clamped: expected %0d, got %0d", e.clamped, out_mon.clamped);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

[verif/tb_quaternion_to_euler_angles.sv]
module tb_quaternion_to_euler_angles;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int DRAIN_CYCLES = STEPS + 60;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   calm;
  bit   hold_req;
  int   quiet_cycles;

  qte_in_if  in_ch ();
  qte_out_if out_ch ();
  qte_cfg_if cfg_ch ();

  quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  qte_scoreboard #(.CORDIC_STEPS(STEPS)) i_scoreboard (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_quaternion_to_euler_angles NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic signed [15:0] z);
    while (!calm && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.q_w <= w;
    in_ch.q_x <= x;
    in_ch.q_y <= y;
    in_ch.q_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_unit(input logic deg);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= deg;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // unit-length quaternion, sometimes pushed toward gimbal lock
  task automatic send_unit_quat();
    real a, b, c, d, n;
    logic signed [15:0] q [4];
    a = real'($urandom_range(2000)) - 1000.0;
    b = real'($urandom_range(2000)) - 1000.0;
    c = real'($urandom_range(2000)) - 1000.0;
    d = real'($urandom_range(2000)) - 1000.0;
    // pair w with y and x with z for pitch near plus or minus ninety
    if ($urandom_range(9) == 0) begin
      c = ($urandom_range(1)) ? a : -a;
      d = ($urandom_range(1)) ? b : -b;
    end
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) begin
      a = 1.0; n = 1.0;
    end
    q[0] = 16'($rtoi(a * 16384.0 / n + (a >= 0 ? 0.5 : -0.5)));
    q[1] = 16'($rtoi(b * 16384.0 / n + (b >= 0 ? 0.5 : -0.5)));
    q[2] = 16'($rtoi(c * 16384.0 / n + (c >= 0 ? 0.5 : -0.5)));
    q[3] = 16'($rtoi(d * 16384.0 / n + (d >= 0 ? 0.5 : -0.5)));
    send_quat(q[0], q[1], q[2], q[3]);
  endtask

  task automatic send_random(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 75) send_unit_quat();
      else send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic send_directed();
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
    send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, 16'sd0, 16'sd32767, 16'sd0);
    send_quat(16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
    send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd32767);
    send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd1);
    send_quat(-16'sd16384, 16'sd0, 16'sd0, -16'sd1);
    send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_quat(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
  endtask

  initial begin
    calm = 1'b0;
    hold_req = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.q_w = '0;
    in_ch.q_x = '0;
    in_ch.q_y = '0;
    in_ch.q_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();
    send_random(230);
    set_unit(1'b1);
    send_directed();
    hold_req = 1'b1;
    send_random(230);
    set_unit(1'b0);
    calm = 1'b1;
    send_random(120);
    calm = 1'b0;
    set_unit(1'b1);
    send_random(120);
    wait_drained();

    if (fail_count == 0 && pending == 0) begin
      $display("tb_quaternion_to_euler_angles OK");
    end else begin
      $display("tb_quaternion_to_euler_angles NOT OK");
    end
    $finish;
  end
endmodule
